// ===== rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// shared constants and helpers for the pressure and temperature compensation
// ----------------------------------------------------------------------------
`default_nettype none
package ptc_pkg;

  localparam int unsigned DivSteps = 32;

  typedef enum logic [1:0] {
    REG_CALIB_T  = 2'd0,
    REG_CALIB_PL = 2'd1,
    REG_CALIB_PM = 2'd2,
    REG_CALIB_P9 = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] rem;
    logic        dbl;
    logic [31:0] temp;
  } div_stage_t;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// integer compensation of raw barometer readings into milli-degC and pascal
// ----------------------------------------------------------------------------
// channel  | dir | fields
// s_*      | in  | tdata: raw_temperature[19:0], raw_pressure[39:20]
// m_*      | out | tdata: temperature_milli_c[31:0], pressure_pa[63:32]
// apb      | in  | calibration registers at byte addresses 0, 8, 16, 24
//
// one transaction per cycle while the output is not stalled; the 32-stage
// radix-2 divider sits between the arithmetic stages around it
// reset clears all valid bits and the calibration registers
// a stall on the output freezes the whole pipeline; tready = !m_tvalid | m_tready
// ----------------------------------------------------------------------------
`default_nettype none
module pressure_temperature_compensation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // raw_temperature, raw_pressure
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // temperature_milli_c, pressure_pa
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import ptc_pkg::*;

  logic [47:0] cal_t_q;
  logic [63:0] cal_pl_q, cal_pm_q;
  logic [15:0] cal_p9_q;
  reg_idx_e    idx;

  assign idx    = reg_idx_e'(paddr[4:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pl_q <= '0;
      cal_pm_q <= '0;
      cal_p9_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_CALIB_T:  cal_t_q  <= pwdata[47:0];
        REG_CALIB_PL: cal_pl_q <= pwdata;
        REG_CALIB_PM: cal_pm_q <= pwdata;
        REG_CALIB_P9: cal_p9_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CALIB_T:  prdata = {16'd0, cal_t_q};
      REG_CALIB_PL: prdata = cal_pl_q;
      REG_CALIB_PM: prdata = cal_pm_q;
      REG_CALIB_P9: prdata = {48'd0, cal_p9_q};
      default:      prdata = '0;
    endcase
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, cal_t_q[15:0]};
  assign t2 = sx16(cal_t_q[31:16]);
  assign t3 = sx16(cal_t_q[47:32]);
  assign p1 = {16'd0, cal_pl_q[15:0]};
  assign p2 = sx16(cal_pl_q[31:16]);
  assign p3 = sx16(cal_pl_q[47:32]);
  assign p4 = sx16(cal_pl_q[63:48]);
  assign p5 = sx16(cal_pm_q[15:0]);
  assign p6 = sx16(cal_pm_q[31:16]);
  assign p7 = sx16(cal_pm_q[47:32]);
  assign p8 = sx16(cal_pm_q[63:48]);
  assign p9 = sx16(cal_p9_q);

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic dv_q [0:DivSteps];
  logic pv1_q, pv2_q, m_tvalid_q;

  // payload
  logic [31:0] s1_at_q, s1_bb_q;
  logic [19:0] s1_ap_q, s2_ap_q, s3_ap_q, s4_ap_q, s5_ap_q, s6_ap_q;
  logic [31:0] s2_a_q, s2_b_q, s3_tf_q;
  logic [31:0] s4_x_q, s4_a_q, s4_qq_q, s4_ap5_q, s4_p2a_q;
  logic [31:0] s5_temp_q, s5_b1_q, s5_c_q, s5_ap5_q, s5_p2a_q;
  logic [31:0] s6_temp_q, s6_b_q, s6_a2_q;
  logic [31:0] s7_temp_q, s7_a3_q, s7_pd_q;
  logic [31:0] s8_temp_q, s8_den_q, s8_pm_q;
  div_stage_t  d_q [0:DivSteps];
  logic [31:0] pp1_p_q, pp1_sq_q, pp1_q2_q, pp1_temp_q;
  logic [31:0] pp2_p_q, pp2_q1_q, pp2_q2_q, pp2_temp_q;
  logic [63:0] m_tdata_q;

  logic [31:0] adc_t, d1, b0, ap, qv, xneg, mag, rnd_mag, bsum, a3s;
  logic [32:0] mag_r;
  logic [31:0] pq;
  assign adc_t    = {12'd0, s_tdata[19:0]};
  assign d1       = (adc_t >> 3) - (t1 << 1);
  assign b0       = (adc_t >> 4) - t1;
  assign ap       = asr(s3_tf_q, 1) - 32'd64000;
  assign qv       = asr(ap, 2);
  assign xneg     = 32'd0 - s4_x_q;
  assign mag      = s4_x_q[31] ? xneg : s4_x_q;
  assign mag_r    = {1'b0, mag} + 33'd2048;
  assign rnd_mag  = {11'd0, mag_r[32:12]};
  assign bsum     = s5_b1_q + (s5_ap5_q << 1);
  assign a3s      = asr(s7_a3_q, 15);
  assign pq       = d_q[DivSteps].dbl ? (d_q[DivSteps].num << 1) : d_q[DivSteps].num;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_at_q  <= d1 * t2;
      s1_bb_q  <= b0 * b0;
      s1_ap_q  <= s_tdata[39:20];
      s2_a_q   <= asr(s1_at_q, 11);
      s2_b_q   <= asr(s1_bb_q, 12) * t3;
      s2_ap_q  <= s1_ap_q;
      s3_tf_q  <= s2_a_q + asr(s2_b_q, 14);
      s3_ap_q  <= s2_ap_q;
      s4_x_q   <= s3_tf_q * 32'd800;
      s4_a_q   <= ap;
      s4_qq_q  <= qv * qv;
      s4_ap5_q <= ap * p5;
      s4_p2a_q <= p2 * ap;
      s4_ap_q  <= s3_ap_q;
      s5_temp_q <= s4_x_q[31] ? (32'd0 - rnd_mag) : rnd_mag;
      s5_b1_q   <= asr(s4_qq_q, 11) * p6;
      s5_c_q    <= p3 * asr(s4_qq_q, 13);
      s5_ap5_q  <= s4_ap5_q;
      s5_p2a_q  <= s4_p2a_q;
      s5_ap_q   <= s4_ap_q;
      s6_temp_q <= s5_temp_q;
      s6_b_q    <= asr(bsum, 2) + (p4 << 16);
      s6_a2_q   <= asr(asr(s5_c_q, 3) + asr(s5_p2a_q, 1), 18) + 32'd32768;
      s6_ap_q   <= s5_ap_q;
      s7_temp_q <= s6_temp_q;
      s7_a3_q   <= s6_a2_q * p1;
      s7_pd_q   <= (32'd1048576 - {12'd0, s6_ap_q}) - asr(s6_b_q, 12);
      s8_temp_q <= s7_temp_q;
      s8_den_q  <= (a3s == 32'd0) ? 32'd1 : a3s;
      s8_pm_q   <= s7_pd_q * 32'd3125;
      d_q[0].num  <= s8_pm_q[31] ? s8_pm_q : (s8_pm_q << 1);
      d_q[0].dbl  <= s8_pm_q[31];
      d_q[0].den  <= s8_den_q;
      d_q[0].rem  <= '0;
      d_q[0].temp <= s8_temp_q;
      pp1_p_q    <= pq;
      pp1_sq_q   <= (pq >> 3) * (pq >> 3);
      pp1_q2_q   <= (pq >> 2) * p8;
      pp1_temp_q <= d_q[DivSteps].temp;
      pp2_p_q    <= pp1_p_q;
      pp2_q1_q   <= asr(p9 * (pp1_sq_q >> 13), 12);
      pp2_q2_q   <= asr(pp1_q2_q, 13);
      pp2_temp_q <= pp1_temp_q;
      m_tdata_q  <= {pp2_p_q + asr(pp2_q1_q + pp2_q2_q + p7, 4), pp2_temp_q};
    end
  end

  // restoring divider, one quotient bit per stage; num shifts out and
  // collects quotient bits from the bottom
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [32:0] trial, diff;
    assign trial = {d_q[k].rem, d_q[k].num[31]};
    assign diff  = trial - {1'b0, d_q[k].den};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_q[k+1].den  <= d_q[k].den;
        d_q[k+1].dbl  <= d_q[k].dbl;
        d_q[k+1].temp <= d_q[k].temp;
        d_q[k+1].rem  <= diff[32] ? trial[31:0] : diff[31:0];
        d_q[k+1].num  <= {d_q[k].num[30:0], ~diff[32]};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      dv_q[0] <= 1'b0;
      pv1_q <= 1'b0; pv2_q <= 1'b0; m_tvalid_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_tvalid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
      dv_q[0] <= v8_q;
      pv1_q <= dv_q[DivSteps]; pv2_q <= pv1_q; m_tvalid_q <= pv2_q;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v8_q |-> s8_den_q != 32'd0) else $error("zero divisor reached divider");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DivSteps] |-> d_q[DivSteps].rem < d_q[DivSteps].den)
    else $error("divider remainder out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> $stable(pv2_q) && $stable(dv_q[0]))
    else $error("pipeline moved during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid |-> s_tready) else $error("input blocked with empty output");
`endif

endmodule
`default_nettype wire

// ===== dv/pressure_temperature_compensation_tb.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_tb
// Raw temperature and pressure readings go in through the stream input. Each
// compensated result is compared with an in-bench calculation of the 32-bit
// integer scheme. The calibration is changed between phases over the register
// port. Random gaps are inserted on both stream sides, and one long output
// stall fills the pipeline.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int Latency = 44;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [31:0] pressure_pa;
    logic [31:0] temperature_milli_c;
  } comp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic [47:0] cal_t;
  logic [63:0] cal_pl;
  logic [63:0] cal_pm;
  logic [15:0] cal_p9;

  comp_result_t expected_results[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          hold_output = 1'b0;

  pressure_temperature_compensation i_dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic comp_result_t compensate(input logic [19:0] raw_t,
                                              input logic [19:0] raw_p);
    logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, t_fine, x, mag, q, p, q1, q2;
    logic [63:0] wide;
    comp_result_t r;
    adc_t = {12'd0, raw_t};
    adc_p = {12'd0, raw_p};
    t1 = {16'd0, cal_t[15:0]};
    t2 = {{16{cal_t[31]}}, cal_t[31:16]};
    t3 = {{16{cal_t[47]}}, cal_t[47:32]};
    p1 = {16'd0, cal_pl[15:0]};
    p2 = {{16{cal_pl[31]}}, cal_pl[31:16]};
    p3 = {{16{cal_pl[47]}}, cal_pl[47:32]};
    p4 = {{16{cal_pl[63]}}, cal_pl[63:48]};
    p5 = {{16{cal_pm[15]}}, cal_pm[15:0]};
    p6 = {{16{cal_pm[31]}}, cal_pm[31:16]};
    p7 = {{16{cal_pm[47]}}, cal_pm[47:32]};
    p8 = {{16{cal_pm[63]}}, cal_pm[63:48]};
    p9 = {{16{cal_p9[15]}}, cal_p9};
    a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    b = (adc_t >> 4) - t1;
    b = sra(sra(b * b, 12) * t3, 14);
    t_fine = a + b;
    x = 32'd800 * t_fine;
    mag = x[31] ? -x : x;
    wide = ({32'd0, mag} + 64'd2048) / 64'd4096;
    q = wide[31:0];
    r.temperature_milli_c = x[31] ? -q : q;
    a = sra(t_fine, 1) - 32'd64000;
    b = sra(a, 2);
    b = sra(b * b, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    q = sra(a, 2);
    a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((a + 32'd32768) * p1, 15);
    if (a == 0) a = 1;
    p = (32'd1048576 - adc_p) - sra(b, 12);
    p = p * 32'd3125;
    if (!p[31]) p = (p << 1) / a;
    else p = (p / a) * 32'd2;
    q1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
    q2 = sra((p >> 2) * p8, 13);
    r.pressure_pa = p + sra(q1 + q2 + p7, 4);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 3;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CALIB_T:  cal_t = value[47:0];
      REG_CALIB_PL: cal_pl = value;
      REG_CALIB_PM: cal_pm = value;
      default:      cal_p9 = value[15:0];
    endcase
  endtask

  task automatic set_calibration(input logic [47:0] t, input logic [63:0] pl,
                                 input logic [63:0] pm, input logic [15:0] p9);
    write_reg(REG_CALIB_T, {16'd0, t});
    write_reg(REG_CALIB_PL, pl);
    write_reg(REG_CALIB_PM, pm);
    write_reg(REG_CALIB_P9, {48'd0, p9});
  endtask

  task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p,
                              input bit gaps);
    int gap;
    gap = 0;
    if (gaps && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {raw_p, raw_t};
    expected_results.push_back(compensate(raw_t, raw_p));
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [47:0] typical_t;
    return {16'hFC18, 16'h6A4C, 16'h6F15};
  endfunction

  task automatic test_reset_calibration;
    send_reading(20'd0, 20'd0, 1'b0);
    send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_reading(20'h80000, 20'h5A5A5, 1'b0);
    drain();
  endtask

  task automatic test_directed;
    set_calibration(typical_t(), {16'h0BB8, 16'h00D0, 16'hD0D0, 16'h93A8},
                    {16'hFFF9, 16'hFF9C, 16'h0064, 16'h1770}, 16'h1770);
    send_reading(20'd519888, 20'd415148, 1'b0);
    send_reading(20'd0, 20'd0, 1'b0);
    send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_reading(20'd0, 20'hFFFFF, 1'b0);
    send_reading(20'hFFFFF, 20'd0, 1'b0);
    send_reading(20'h55555, 20'hAAAAA, 1'b0);
    send_reading(20'hAAAAA, 20'h55555, 1'b0);
    drain();
    set_calibration(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_reading(20'd0, 20'd0, 1'b0);
    send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_reading(20'd519888, 20'd415148, 1'b0);
    drain();
    set_calibration({16'h7FFF, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                    {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_reading(20'd0, 20'hFFFFF, 1'b0);
    send_reading(20'hFFFFF, 20'd0, 1'b0);
    send_reading(20'h12345, 20'h6789A, 1'b0);
    drain();
    // pressure divisor zero: p1 zero forces it to one
    set_calibration(typical_t(), {16'h0000, 16'h00D0, 16'hD0D0, 16'h0000}, '0, 16'h0000);
    send_reading(20'd519888, 20'd415148, 1'b0);
    send_reading(20'd300000, 20'd10, 1'b0);
    drain();
    // negative divisor term
    write_reg(REG_CALIB_PL, {16'h0000, 16'h0000, 16'h8000, 16'hFFFF});
    send_reading(20'hFFFFF, 20'd500000, 1'b0);
    send_reading(20'd0, 20'd1, 1'b0);
    drain();
  endtask

  task automatic test_random_phases;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase % 2 == 0)
        set_calibration(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, 16'($urandom()));
      else
        set_calibration(typical_t() ^ 48'($urandom_range(0, 255)),
                        {16'h0BB8, 16'h00D0, 16'hD0D0, 16'h8F00 | 16'($urandom_range(0, 4095))},
                        {16'hFFF9, 16'hFF9C, 16'h0064 ^ 16'($urandom_range(0, 63)), 16'h1770},
                        16'h1770);
      if (phase == 2) hold_output = 1'b1;
      for (int n = 0; n < 150; n++) begin
        if (phase % 2 == 1)
          send_reading(20'($urandom_range(400000, 600000)),
                       20'($urandom_range(250000, 500000)), 1'b1);
        else
          send_reading(20'($urandom()), 20'($urandom()), 1'b1);
      end
      drain();
    end
  endtask

  // output side: random stalls plus one long hold-off
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_output = 1'b0;
      end
      stall = 0;
      if ($urandom_range(0, 4) == 0)
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    comp_result_t want;
    comp_result_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        $display("unexpected transaction %h", m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.temperature_milli_c !== want.temperature_milli_c)
          report_mismatch("temperature_milli_c", got.temperature_milli_c,
                          want.temperature_milli_c);
        if (got.pressure_pa !== want.pressure_pa)
          report_mismatch("pressure_pa", got.pressure_pa, want.pressure_pa);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cal_t = '0;
    cal_pl = '0;
    cal_pm = '0;
    cal_p9 = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_calibration();
    test_directed();
    test_random_phases();
    if (expected_results.size() != 0) error_count++;
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ptc_pkg.sv
rtl/pressure_temperature_compensation.sv
dv/pressure_temperature_compensation_tb.sv
